// ===== rtl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the stream byte reassembler
// Field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned WIN_W  = 7;   // window register and held count width
  localparam int unsigned OFF_W  = 32;  // stream offset width
  localparam int unsigned BYTE_W = 8;   // data byte width

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input word
    logic insert;     // store the byte, update the end marker, start the scan
    logic scan_step;  // the slot under the scan pointer is held: advance
    logic scan_done;  // run length known: settle counts and finished flag
    logic emit;       // load one result word into the output register
  } srb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;  // scan pointer slot is held and the run is below depth
    logic rem_zero;   // no byte left to release
    logic rem_one;    // exactly one byte left to release
    logic out_free;   // output register can take a word this cycle
  } srb_sts_t;

endpackage

// ===== rtl/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/srb_datapath.sv =====
// ----------------------------------------------------------------------------
// srb_datapath: storage and arithmetic of the stream byte reassembler
// Window register, input latch, valid map, byte RAM, offsets, run scan and
// the output register.
// ----------------------------------------------------------------------------
module srb_datapath
  import srb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srb_cmd_t          cmd_i,
  output srb_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [WIN_W-1:0]  cfg_wdata_i,
  input  logic              has_byte_i,
  input  logic [OFF_W-1:0]  byte_index_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              segment_end_i,
  input  logic              out_ready_i,
  output logic              out_tvalid_o,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [OFF_W-1:0]  out_offset_o,
  output logic              last_of_run_o,
  output logic [WIN_W-1:0]  pending_count_o,
  output logic              stream_finished_o
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [WIN_W-1:0] DepthWin = WIN_W'(STORE_DEPTH);
  localparam logic [IDX_W:0]   DepthSum = (IDX_W+1)'(STORE_DEPTH);
  localparam logic [IDX_W-1:0] LastSlot = IDX_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(STORE_DEPTH);

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  logic [WIN_W-1:0]       window_q;
  logic                   has_q, seg_q;
  logic [OFF_W-1:0]       idx_q;
  logic [BYTE_W-1:0]      val_q;
  logic [STORE_DEPTH-1:0] valid_q;
  logic [OFF_W-1:0]       next_q, end_q;
  logic                   end_known_q, fin_q;
  logic [WIN_W-1:0]       held_q;
  logic [IDX_W-1:0]       head_q, head_d, ptr_q;
  logic [CNT_W-1:0]       cnt_q, rem_q;

  logic                   out_vld_q, out_flag_q, out_last_q, out_fin_q;
  logic [BYTE_W-1:0]      out_byte_q;
  logic [OFF_W-1:0]       out_off_q;
  logic [WIN_W-1:0]       out_pend_q;

  logic [WIN_W-1:0]       eff_win;
  logic [OFF_W-1:0]       byte_dist;
  logic                   in_win, wr_en, slot_held, head_adv, reach_end;
  logic [IDX_W:0]         slot_sum;
  logic [IDX_W-1:0]       slot;
  logic [BYTE_W-1:0]      ram_rdata;

  always_comb begin
    if (window_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_q > DepthWin) begin
      eff_win = DepthWin;
    end else begin
      eff_win = window_q;
    end
  end

  // Old bytes wrap to a huge distance, so one compare drops both old and far bytes.
  assign byte_dist = idx_q - next_q;
  assign in_win    = byte_dist < OFF_W'(eff_win);
  assign slot_sum  = {1'b0, head_q} + {1'b0, byte_dist[IDX_W-1:0]};
  assign slot      = (slot_sum >= DepthSum) ? IDX_W'(slot_sum - DepthSum)
                                            : slot_sum[IDX_W-1:0];
  assign wr_en     = cmd_i.insert && has_q && in_win;
  assign slot_held = valid_q[slot];
  assign head_adv  = cmd_i.emit && (rem_q != '0);
  assign head_d    = head_adv ? slot_inc(head_q) : head_q;
  assign reach_end = end_known_q && ((next_q + OFF_W'(cnt_q)) == end_q);

  assign sts_o.scan_more = valid_q[ptr_q] && (cnt_q != DepthCnt);
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.rem_one   = (rem_q == CNT_W'(1));
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // The read address follows the next head so the data of the current head
  // is already registered when a byte is released.
  srb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot),
    .wdata_i(val_q),
    .raddr_i(head_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      has_q <= has_byte_i;
      idx_q <= byte_index_i;
      val_q <= byte_value_i;
      seg_q <= segment_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      next_q      <= '0;
      end_q       <= '0;
      end_known_q <= 1'b0;
      held_q      <= '0;
      fin_q       <= 1'b0;
      head_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
    end else begin
      head_q <= head_d;
      if (cmd_i.insert) begin
        if (wr_en) begin
          valid_q[slot] <= 1'b1;
          if (!slot_held) begin
            held_q <= held_q + 1'b1;
          end
        end
        if (seg_q) begin
          end_q       <= idx_q + OFF_W'(has_q);
          end_known_q <= 1'b1;
        end
        ptr_q <= head_q;
        cnt_q <= '0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= slot_inc(ptr_q);
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.scan_done) begin
        rem_q  <= cnt_q;
        held_q <= held_q - WIN_W'(cnt_q);
        if (reach_end) begin
          fin_q <= 1'b1;
        end
      end
      if (head_adv) begin
        valid_q[head_q] <= 1'b0;
        next_q          <= next_q + 1'b1;
        rem_q           <= rem_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_flag_q <= !sts_o.rem_zero;
      out_byte_q <= sts_o.rem_zero ? '0 : ram_rdata;
      out_off_q  <= next_q;
      out_last_q <= sts_o.rem_zero || sts_o.rem_one;
      out_pend_q <= held_q;
      out_fin_q  <= fin_q;
    end
  end

  assign out_tvalid_o      = out_vld_q;
  assign out_valid_o       = out_flag_q;
  assign out_byte_o        = out_byte_q;
  assign out_offset_o      = out_off_q;
  assign last_of_run_o     = out_last_q;
  assign pending_count_o   = out_pend_q;
  assign stream_finished_o = out_fin_q;

endmodule

// ===== rtl/srb_ctrl.sv =====
// ----------------------------------------------------------------------------
// srb_ctrl: sequencing state machine of the stream byte reassembler
// Steps each word through capture, insert, run scan and release.
// ----------------------------------------------------------------------------
module srb_ctrl
  import srb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  srb_sts_t sts_i,
  output srb_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StInsert = 2'd1;
  localparam logic [1:0] StScan   = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StInsert;
        end
      end
      StInsert: begin
        cmd_o.insert = 1'b1;
        state_d      = StScan;
      end
      StScan: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.scan_done = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.rem_zero || sts_i.rem_one) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/stream_byte_reassembler.sv =====
// ----------------------------------------------------------------------------
// stream_byte_reassembler: out-of-order byte stream reassembly
// Holds bytes that arrive inside the receive window and releases the
// contiguous run from the next expected offset in stream order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)                     tuser     tlast
//  s_axis    in         byte_index[31:0] byte_value[39:32]     has_byte  segment_end
//  m_axis    out        out_byte[7:0] out_offset[39:8]         out_valid last_of_run
//                       pending_count[46:40] stream_finished[47]
//  cfg       in         window_size[6:0], written when cfg_we_i is high
//
//  One word is handled at a time. Each word is captured, inserted and then
//  scanned, one slot of the valid map per cycle, to find the run length
//  before release; a word that releases no byte gives a single status
//  result. The output register takes one result per cycle while m_axis
//  does not stall. The next word is accepted while the last result still
//  waits in the output register; m_axis stalls hold the release.
//  Reset clears the valid map and all offsets at once; the byte RAM is not
//  cleared, since a slot is read only while its valid bit is set.
//
module stream_byte_reassembler
  import srb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,    // window_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // byte_index[31:0], byte_value[39:32]
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // segment_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_byte[7:0], out_offset[39:8],
                                      // pending_count[46:40], stream_finished[47]
  output logic        m_axis_tuser,   // out_valid
  output logic        m_axis_tlast    // last_of_run
);

  srb_cmd_t          cmd;
  srb_sts_t          sts;
  logic [BYTE_W-1:0] out_byte;
  logic [OFF_W-1:0]  out_offset;
  logic [WIN_W-1:0]  pending_count;
  logic              stream_finished;

  // The controller only sequences; all state of the stream lives in the datapath.
  srb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  srb_datapath #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .has_byte_i       (s_axis_tuser),
    .byte_index_i     (s_axis_tdata[31:0]),
    .byte_value_i     (s_axis_tdata[39:32]),
    .segment_end_i    (s_axis_tlast),
    .out_ready_i      (m_axis_tready),
    .out_tvalid_o     (m_axis_tvalid),
    .out_valid_o      (m_axis_tuser),
    .out_byte_o       (out_byte),
    .out_offset_o     (out_offset),
    .last_of_run_o    (m_axis_tlast),
    .pending_count_o  (pending_count),
    .stream_finished_o(stream_finished)
  );

  assign m_axis_tdata = {stream_finished, pending_count, out_offset, out_byte};

`ifndef NO_ASSERTIONS
  // Only one word is in work at a time.
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is still in work");

  // A status-only result is always the single, final result of its word.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status result without last_of_run");

  // The held byte count never exceeds the store depth.
  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[46:40] <= WIN_W'(STORE_DEPTH))
    else $error("pending count beyond store depth");

  // Once finished, the flag stays set on every later result.
  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[47] && $past(1'b1)
    |=> !m_axis_tvalid || m_axis_tdata[47])
    else $error("stream_finished dropped after being set");
`endif

endmodule
